// ----- sv/fpq_pkg.sv -----
package fpq_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
    OP_MIN = 4'd12, OP_MAX = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK = 2'd0, ERR_DIV0 = 2'd1, ERR_OVF = 2'd2
  } err_t;

  // divider state handed from cell to cell
  typedef struct packed {
    logic          vld;
    logic          neg;
    logic          div0;
    logic [63:0]   rem;
    logic [63:0]   quo;
    logic [32:0]   den2;
    logic          fast;
    logic [31:0]   fast_res;
    logic          fast_cmp;
    logic [1:0]    fast_err;
  } cell_t;

endpackage

// ----- sv/fpq_if.sv -----
interface fpq_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, op, operand_a, operand_b, input ready);
  modport sink (input valid, op, operand_a, operand_b, output ready);
endinterface

interface fpq_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result;
  logic        compare_true;
  logic [1:0]  error;
  modport source (output valid, result, compare_true, error, input ready);
  modport sink (input valid, result, compare_true, error, output ready);
endinterface

// ----- sv/fpq_cell.sv -----
// One restoring-division step on a (2x-numerator + denominator) / 2x-denominator pair.
module fpq_cell
  import fpq_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  cell_t c_in,
  output cell_t c_out
);
  cell_t nxt;
  logic [96:0] sh;

  always_comb begin
    nxt = c_in;
    sh  = {64'd0, c_in.den2} << BIT;
    if (!c_in.fast && !c_in.div0 && ({33'd0, c_in.rem} >= sh)) begin
      nxt.rem = c_in.rem - sh[63:0];
      nxt.quo = c_in.quo | (64'd1 << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_out.vld <= 1'b0;
    end else if (en) begin
      c_out <= nxt;
    end
  end
endmodule

// ----- sv/fpq_front.sv -----
// Operand decode: combinational ops and multiplier plus divide setup, registered, feeding the chain.
module fpq_front
  import fpq_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld,
  input  logic [3:0]  op,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output cell_t       c_out
);
  cell_t nxt;
  logic signed [33:0] s;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic signed [64:0] sv;
  logic [63:0] mg;
  logic neg;

  function automatic logic [33:0] sat32(input logic signed [65:0] v, output logic o);
    if (v > 66'sd2147483647) begin
      o = 1'b1; return {2'b00, 32'h7fffffff};
    end else if (v < -66'sd2147483648) begin
      o = 1'b1; return {2'b11, 32'h80000000};
    end else begin
      o = 1'b0; return v[33:0];
    end
  endfunction

  always_comb begin
    logic o;
    logic [33:0] t;
    nxt = '0;
    nxt.vld = vld;
    nxt.fast = 1'b1;
    ma = a[31] ? 32'(-a) : 32'(a);
    mb = b[31] ? 32'(-b) : 32'(b);
    neg = a[31] ^ b[31];
    prod = 64'(ma) * 64'(mb);
    s = '0;
    o = 1'b0;
    mg = '0;
    sv = '0;
    t = '0;
    case (op_t'(op))
      OP_ADD: s = 34'(a) + 34'(b);
      OP_SUB: s = 34'(a) - 34'(b);
      OP_INC: s = 34'(a) + 34'sd1;
      OP_DEC: s = 34'(a) - 34'sd1;
      default: s = '0;
    endcase
    case (op_t'(op))
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        t = sat32(66'(s), o);
        nxt.fast_res = t[31:0];
        nxt.fast_err = o ? ERR_OVF : ERR_OK;
      end
      OP_MUL: begin
        mg = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        sv = neg ? -$signed({1'b0, mg}) : $signed({1'b0, mg});
        t = sat32(66'(sv), o);
        nxt.fast_res = t[31:0];
        nxt.fast_err = o ? ERR_OVF : ERR_OK;
      end
      OP_FROMINT: begin
        mg = 64'(ma) << FRAC_BITS;
        sv = a[31] ? -$signed({1'b0, mg}) : $signed({1'b0, mg});
        t = sat32(66'(sv), o);
        nxt.fast_res = t[31:0];
        nxt.fast_err = o ? ERR_OVF : ERR_OK;
      end
      OP_DIV: begin
        nxt.fast = 1'b0;
        nxt.neg = neg;
        nxt.div0 = (b == 32'sd0);
        nxt.rem = (64'(ma) << (FRAC_BITS + 1)) + 64'(mb);
        nxt.den2 = {mb, 1'b0};
      end
      OP_GT: nxt.fast_cmp = a > b;
      OP_LT: nxt.fast_cmp = a < b;
      OP_GE: nxt.fast_cmp = a >= b;
      OP_LE: nxt.fast_cmp = a <= b;
      OP_EQ: nxt.fast_cmp = a == b;
      OP_NE: nxt.fast_cmp = a != b;
      OP_MIN: nxt.fast_res = (a < b) ? a : b;
      OP_MAX: nxt.fast_res = (a > b) ? a : b;
      OP_TOINT: nxt.fast_res = 32'(a >>> FRAC_BITS);
      default: nxt.fast_res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_out.vld <= 1'b0;
    end else if (en) begin
      c_out <= nxt;
    end
  end
endmodule

// ----- sv/fixed_point_alu_q8_unit.sv -----
// Signed fixed-point ALU, raw 32-bit words with FRAC_BITS fraction bits.
// Input channel in (op, operand_a, operand_b), result channel out
// (result, compare_true, error). Valid/ready, item moves when both high.
// Throughput: one item per cycle unless out_ready stalls the chain. Every
// op passes the division chain: one decode stage, then one cell per
// quotient bit (FRAC_BITS + 33 cells, one restoring step each), then a
// saturation/output register. Non-divide ops ride the chain unchanged so
// results leave in order.
// With out_ready low and a full output slot the chain holds; in_ready
// follows out_ready or an empty output slot, so no item is lost or repeated.
// Reset (rst_n low, synchronous) empties all stages; no item is pending.
module fixed_point_alu_q8_unit
  import fpq_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input logic clk,
  input logic rst_n,
  fpq_in_if.sink   in_ch,
  fpq_out_if.source out_ch
);
  localparam int NB = FRAC_BITS + 33;

  cell_t chain [NB+1];
  logic en;
  logic out_v_r;
  logic [31:0] res_r;
  logic cmp_r;
  logic [1:0] err_r;

  assign en = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  fpq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld(in_ch.valid), .op(in_ch.op), .a(in_ch.operand_a), .b(in_ch.operand_b),
    .c_out(chain[0])
  );

  for (genvar i = 0; i < NB; i++) begin : g_cell
    fpq_cell #(.BIT(NB - 1 - i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .c_in(chain[i]), .c_out(chain[i+1])
    );
  end

  // final sign and saturation of the quotient
  cell_t lst;
  logic [31:0] res_nxt;
  logic [1:0] err_nxt;
  assign lst = chain[NB];
  always_comb begin
    res_nxt = lst.fast_res;
    err_nxt = lst.fast_err;
    if (!lst.fast) begin
      if (lst.div0) begin
        res_nxt = '0;
        err_nxt = ERR_DIV0;
      end else if (!lst.neg) begin
        if (lst.quo > 64'h7fffffff) begin
          res_nxt = 32'h7fffffff; err_nxt = ERR_OVF;
        end else begin
          res_nxt = lst.quo[31:0]; err_nxt = ERR_OK;
        end
      end else begin
        if (lst.quo > 64'h80000000) begin
          res_nxt = 32'h80000000; err_nxt = ERR_OVF;
        end else begin
          res_nxt = 32'(-lst.quo[31:0]); err_nxt = ERR_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= lst.vld;
      res_r <= res_nxt;
      cmp_r <= lst.fast ? lst.fast_cmp : 1'b0;
      err_r <= err_nxt;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.result = res_r;
  assign out_ch.compare_true = cmp_r;
  assign out_ch.error = err_r;
endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb
  import fpq_pkg::*;
();

  localparam int FB = 8;
  localparam int LATENCY = FB + 35;
  localparam int STALL_LIMIT = 4000;
  localparam int N_RANDOM = 950;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] result;
    logic               compare_true;
    logic [1:0]         error;
  } alu_res_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               known;   // expected result typed in the table
    alu_res_t           res;
  } vec_t;

  logic clk;
  logic rst_n;
  fpq_in_if  in_ch();
  fpq_out_if out_ch();

  fixed_point_alu_q8_unit #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  alu_res_t pending_q[$];
  int       n_errors = 0;
  int       idle_cycles = 0;
  bit       timed_out;
  bit       stim_done;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // clamp a 64-bit value into the 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v,
                                               inout logic [1:0] err);
    if (v > 64'sh7fffffff) begin
      err = ERR_OVF;
      return MAXV;
    end
    if (v < -64'sh80000000) begin
      err = ERR_OVF;
      return MINV;
    end
    return v[31:0];
  endfunction

  // from_int: magnitude shifted up, sign put back
  function automatic logic signed [63:0] neg_shift(input logic [63:0] mag, input logic neg);
    logic signed [63:0] v;
    v = $signed(mag << FB);
    return neg ? -v : v;
  endfunction

  function automatic alu_res_t alu_predict(input op_t op, input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    alu_res_t r;
    logic signed [63:0] a64, b64, s;
    logic [63:0] ma, mb, m, num, den;
    logic [1:0] err;
    logic neg;
    a64 = a;
    b64 = b;
    ma = a64 < 0 ? -a64 : a64;
    mb = b64 < 0 ? -b64 : b64;
    neg = (a < 0) != (b < 0);
    err = ERR_OK;
    r = '0;
    case (op)
      OP_ADD: r.result = sat32(a64 + b64, err);
      OP_SUB: r.result = sat32(a64 - b64, err);
      OP_MUL: begin
        m = (ma * mb + (64'd1 << (FB - 1))) >> FB;
        s = neg ? -$signed(m) : $signed(m);
        r.result = sat32(s, err);
      end
      OP_DIV: begin
        if (b == 0) begin
          err = ERR_DIV0;
        end else begin
          num = ma << FB;
          den = mb;
          m = (2 * num + den) / (2 * den);
          s = neg ? -$signed(m) : $signed(m);
          r.result = sat32(s, err);
        end
      end
      OP_GT: r.compare_true = a > b;
      OP_LT: r.compare_true = a < b;
      OP_GE: r.compare_true = a >= b;
      OP_LE: r.compare_true = a <= b;
      OP_EQ: r.compare_true = a == b;
      OP_NE: r.compare_true = a != b;
      OP_INC: r.result = sat32(a64 + 1, err);
      OP_DEC: r.result = sat32(a64 - 1, err);
      OP_MIN: r.result = (a < b) ? a : b;
      OP_MAX: r.result = (a > b) ? a : b;
      OP_TOINT: r.result = a >>> FB;
      default: begin
        s = neg_shift(ma, a < 0);
        r.result = sat32(s, err);
      end
    endcase
    r.error = err;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $time);
    n_errors++;
  endtask

  // random operand biased toward limits and small values
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return MAXV - $urandom_range(0, 3);
      1: return MINV + $urandom_range(0, 3);
      2: return $signed($urandom_range(0, 2047)) - 1024;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  // valid drops only when an idle gap follows
  task automatic send(input op_t op, input logic signed [31:0] a, input logic signed [31:0] b);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_q.push_back(alu_predict(op, a, b));
  endtask

  // directed vectors: extremes, every op, divide by zero, saturation
  vec_t table_v[] = '{
    '{OP_ADD, MAXV, 32'sd1, 1'b1, '{MAXV, 1'b0, ERR_OVF}},
    '{OP_SUB, MINV, 32'sd1, 1'b1, '{MINV, 1'b0, ERR_OVF}},
    '{OP_ADD, MINV, MINV, 1'b1, '{MINV, 1'b0, ERR_OVF}},
    '{OP_MUL, MAXV, MAXV, 1'b1, '{MAXV, 1'b0, ERR_OVF}},
    '{OP_MUL, MINV, MAXV, 1'b1, '{MINV, 1'b0, ERR_OVF}},
    '{OP_MUL, 32'sd384, -32'sd1, 1'b0, '0},
    '{OP_MUL, 32'sd128, 32'sd1, 1'b0, '0},
    '{OP_DIV, 32'sd256, 32'sd0, 1'b1, '{32'sd0, 1'b0, ERR_DIV0}},
    '{OP_DIV, MINV, 32'sd0, 1'b1, '{32'sd0, 1'b0, ERR_DIV0}},
    '{OP_DIV, MINV, 32'sd1, 1'b1, '{MINV, 1'b0, ERR_OVF}},
    '{OP_DIV, 32'sd1, 32'sd512, 1'b0, '0},
    '{OP_DIV, -32'sd1, 32'sd512, 1'b0, '0},
    '{OP_GT, MAXV, MINV, 1'b1, '{32'sd0, 1'b1, ERR_OK}},
    '{OP_LT, MAXV, MINV, 1'b1, '{32'sd0, 1'b0, ERR_OK}},
    '{OP_GE, 32'sd5, 32'sd5, 1'b1, '{32'sd0, 1'b1, ERR_OK}},
    '{OP_LE, MINV, MINV, 1'b1, '{32'sd0, 1'b1, ERR_OK}},
    '{OP_EQ, -32'sd1, -32'sd1, 1'b1, '{32'sd0, 1'b1, ERR_OK}},
    '{OP_NE, -32'sd1, -32'sd1, 1'b1, '{32'sd0, 1'b0, ERR_OK}},
    '{OP_INC, MAXV, 32'sd0, 1'b1, '{MAXV, 1'b0, ERR_OVF}},
    '{OP_DEC, MINV, 32'sd0, 1'b1, '{MINV, 1'b0, ERR_OVF}},
    '{OP_MIN, MINV, MAXV, 1'b1, '{MINV, 1'b0, ERR_OK}},
    '{OP_MAX, MINV, MAXV, 1'b1, '{MAXV, 1'b0, ERR_OK}},
    '{OP_TOINT, -32'sd1, 32'sd0, 1'b1, '{-32'sd1, 1'b0, ERR_OK}},
    '{OP_FROMINT, 32'sh00800000, 32'sd0, 1'b1, '{MAXV, 1'b0, ERR_OVF}},
    '{OP_FROMINT, -32'sh00800000, 32'sd0, 1'b1, '{MINV, 1'b0, ERR_OK}}
  };

  // stimulus
  initial begin
    alu_res_t chk;
    stim_done = 0;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.op = OP_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (table_v[i]) begin
      if (table_v[i].known) begin
        chk = alu_predict(table_v[i].op, table_v[i].a, table_v[i].b);
        if (chk != table_v[i].res)
          report("table row", i, 0);
      end
      send(table_v[i].op, table_v[i].a, table_v[i].b);
    end
    repeat (N_RANDOM) send(op_t'($urandom_range(0, 15)), rand_word(), rand_word());
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // result sink with random stalls; ready drops only when a gap follows
  initial begin
    int gap;
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    alu_res_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        report("unexpected result", out_ch.result, 0);
      end else begin
        exp_r = pending_q.pop_front();
        if (out_ch.result !== exp_r.result)
          report("result", out_ch.result, exp_r.result);
        if (out_ch.compare_true !== exp_r.compare_true)
          report("compare_true", 32'(out_ch.compare_true), 32'(exp_r.compare_true));
        if (out_ch.error !== exp_r.error)
          report("error", 32'(out_ch.error), 32'(exp_r.error));
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    timed_out = 0;
    fork
      begin
        wait (stim_done && pending_q.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
      end
      begin
        wait (idle_cycles >= STALL_LIMIT);
        timed_out = 1;
      end
    join_any
    if (timed_out || n_errors != 0) begin
      $display("Regression FAIL");
    end else begin
      $display("Regression PASS");
    end
    $finish;
  end

endmodule
